### hdl/hsc_pkg.sv
// Shared types, codes and constant functions for the Hamming single-error-correcting codec.
package hsc_pkg;

  // Width of a syndrome, and so of an error position; covers code positions 1 to 63.
  localparam int SynW = 6;

  // Width of the data-bit count register.
  localparam int CountW = 6;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_e;

  // Status that travels with a result code word.
  typedef struct packed {
    logic [SynW-1:0] error_position;
    logic            out_of_range;
  } status_t;

  // Least number of parity bits r with 2^r >= m + r + 1.
  function automatic int parity_count(int m);
    int   r;
    logic found;
    r     = 1;
    found = 1'b0;
    for (int t = 1; t <= SynW + 1; t++) begin
      if (!found && ((1 << t) >= m + t + 1)) begin
        r     = t;
        found = 1'b1;
      end
    end
    return r;
  endfunction

  // One-based code position of data bit j: the j-th position that is not a power of two.
  function automatic int data_pos(int j);
    int count;
    int pos;
    count = 0;
    pos   = 0;
    for (int p = 1; p < (1 << SynW); p++) begin
      if ((p & (p - 1)) != 0) begin
        if (count == j) begin
          pos = p;
        end
        count++;
      end
    end
    return pos;
  endfunction

endpackage

### hdl/hamming_sec_codec.sv
// Top level of the shortened Hamming single-error-correcting codec with its handshake registers.
//
//   channel   direction  handshake                   payload
//   input     in         in_valid_i / in_stall_o     cmd_i, data_word_i, code_word_i
//   result    out        out_valid_o / out_stall_i   code_out_o, error_position_o,
//                                                    position_out_of_range_o
//   config    in         data_bits_we_i              data_bits_i
//
// Every transaction passes through the input register and then the result register, with the
// encode or check logic between them (one XOR tree per syndrome bit). A new transaction can be
// accepted in every cycle while the result side is not stalled, so the sustained rate is one
// per cycle. Reset empties both registers and sets the data-bit count to four. A stall on
// the result side holds the result; the input register still takes a transaction as long as
// the result register is free or is being emptied in the same cycle.
module hamming_sec_codec #(
  parameter int MAX_DATA_BITS = 57
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   data_bits_we_i,
  input  logic [hsc_pkg::CountW-1:0]             data_bits_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   cmd_i,
  input  logic [MAX_DATA_BITS-1:0]               data_word_i,
  input  logic [MAX_DATA_BITS +
                hsc_pkg::parity_count(MAX_DATA_BITS) - 1:0] code_word_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [MAX_DATA_BITS +
                hsc_pkg::parity_count(MAX_DATA_BITS) - 1:0] code_out_o,
  output logic [hsc_pkg::SynW-1:0]               error_position_o,
  output logic                                   position_out_of_range_o
);

  localparam int DataW = MAX_DATA_BITS;
  localparam int CodeW = MAX_DATA_BITS + hsc_pkg::parity_count(MAX_DATA_BITS);
  localparam int ResetM = (MAX_DATA_BITS < 4) ? MAX_DATA_BITS : 4;
  localparam int ResetN = ResetM + hsc_pkg::parity_count(ResetM);

  // The configured count is clamped to 1..MAX_DATA_BITS when written, and the code length
  // is worked out at the same time so that neither sits in the datapath.
  logic [hsc_pkg::CountW-1:0] m_d, m_q;
  logic [hsc_pkg::CountW-1:0] n_d, n_q;

  always_comb begin
    if (data_bits_i == '0) begin
      m_d = hsc_pkg::CountW'(1);
    end else if (int'(data_bits_i) > MAX_DATA_BITS) begin
      m_d = hsc_pkg::CountW'(MAX_DATA_BITS);
    end else begin
      m_d = data_bits_i;
    end
    n_d = hsc_pkg::CountW'(int'(m_d) + hsc_pkg::parity_count(int'(m_d)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= hsc_pkg::CountW'(ResetM);
      n_q <= hsc_pkg::CountW'(ResetN);
    end else if (data_bits_we_i) begin
      m_q <= m_d;
      n_q <= n_d;
    end
  end

  // Input register.
  logic             s1_valid_q;
  logic             s1_cmd_q;
  logic [DataW-1:0] s1_data_q;
  logic [CodeW-1:0] s1_code_q;
  logic             s1_load;
  logic             out_load;

  // The result register may load when it is empty or its transaction leaves this cycle.
  assign out_load   = !out_valid_o || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_load;
  assign s1_load    = !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      s1_cmd_q  <= cmd_i;
      s1_data_q <= data_word_i;
      s1_code_q <= code_word_i;
    end
  end

  logic [CodeW-1:0] core_code;
  hsc_pkg::status_t core_status;

  hsc_core #(
    .DataW (DataW),
    .CodeW (CodeW)
  ) u_core (
    .cmd_i    (s1_cmd_q),
    .data_i   (s1_data_q),
    .code_i   (s1_code_q),
    .m_i      (m_q),
    .n_i      (n_q),
    .code_o   (core_code),
    .status_o (core_status)
  );

  // Result register.
  logic             out_valid_q;
  logic [CodeW-1:0] out_code_q;
  hsc_pkg::status_t out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      out_code_q   <= core_code;
      out_status_q <= core_status;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign code_out_o              = out_code_q;
  assign error_position_o        = out_status_q.error_position;
  assign position_out_of_range_o = out_status_q.out_of_range;

  // The input side is only held off while the input register is occupied.
  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty input register");

  // A transaction in the input register moves on whenever the result register can load.
  a_stage_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_load) |=> out_valid_o)
    else $error("transaction lost between input and result registers");

  // An out-of-range flag always comes with a non-zero syndrome.
  a_range_has_syndrome : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && position_out_of_range_o) |-> (error_position_o != '0))
    else $error("out-of-range flag with a zero syndrome");

endmodule

### hdl/hsc_syndrome.sv
// Syndrome generator: XOR of the one-based positions of all set bits of a code word.
module hsc_syndrome #(
  parameter int CodeW = 63
) (
  input  logic [CodeW-1:0]         word_i,
  output logic [hsc_pkg::SynW-1:0] syndrome_o
);

  // Positions whose one-based index has bit b set.
  function automatic logic [CodeW-1:0] col_mask(int b);
    logic [CodeW-1:0] mask;
    mask = '0;
    for (int k = 0; k < CodeW; k++) begin
      mask[k] = (((k + 1) >> b) & 1) != 0;
    end
    return mask;
  endfunction

  always_comb begin
    for (int b = 0; b < hsc_pkg::SynW; b++) begin
      syndrome_o[b] = ^(word_i & col_mask(b));
    end
  end

endmodule

### hdl/hsc_core.sv
// Encode and check-and-correct datapath between the input and result registers.
module hsc_core #(
  parameter int DataW = 57,
  parameter int CodeW = 63
) (
  input  logic                       cmd_i,
  input  logic [DataW-1:0]           data_i,
  input  logic [CodeW-1:0]           code_i,
  input  logic [hsc_pkg::CountW-1:0] m_i,
  input  logic [hsc_pkg::CountW-1:0] n_i,
  output logic [CodeW-1:0]           code_o,
  output hsc_pkg::status_t           status_o
);

  logic [CodeW-1:0]         code_mask;
  logic [CodeW-1:0]         scattered;
  logic [CodeW-1:0]         syn_word;
  logic [CodeW-1:0]         encoded;
  logic [CodeW-1:0]         flip;
  logic [hsc_pkg::SynW-1:0] syndrome;
  logic                     decode;
  logic                     beyond;

  assign decode = (cmd_i == hsc_pkg::CMD_DECODE);

  always_comb begin
    for (int k = 0; k < CodeW; k++) begin
      code_mask[k] = (k < int'(n_i));
    end
  end

  // Data bits go to fixed positions; only the configured count is kept.
  always_comb begin
    scattered = '0;
    for (int j = 0; j < DataW; j++) begin
      scattered[hsc_pkg::data_pos(j) - 1] = data_i[j] & (j < int'(m_i));
    end
  end

  // One syndrome unit serves both commands.
  assign syn_word = decode ? (code_i & code_mask) : scattered;

  hsc_syndrome #(
    .CodeW (CodeW)
  ) u_syndrome (
    .word_i     (syn_word),
    .syndrome_o (syndrome)
  );

  // Parity at position 2^i takes syndrome bit i, which makes the word's syndrome zero.
  always_comb begin
    encoded = scattered;
    for (int i = 0; i < hsc_pkg::SynW; i++) begin
      if ((1 << i) <= CodeW) begin
        encoded[(1 << i) - 1] = syndrome[i];
      end
    end
  end

  assign beyond = (syndrome > n_i);

  always_comb begin
    for (int k = 0; k < CodeW; k++) begin
      flip[k] = !beyond && (int'(syndrome) == k + 1);
    end
  end

  always_comb begin
    if (decode) begin
      code_o                  = (syn_word ^ flip) & code_mask;
      status_o.error_position = syndrome;
      status_o.out_of_range   = beyond;
    end else begin
      code_o                  = encoded & code_mask;
      status_o.error_position = '0;
      status_o.out_of_range   = 1'b0;
    end
  end

endmodule

### tb/hamming_sec_codec_tb.sv
// Self-checking testbench for the shortened Hamming single-error-correcting codec.
module hamming_sec_codec_tb;

  // The block is built at its widest, so that every data bit count can be set at run time.
  localparam int DataW        = 57;
  localparam int CodeW        = DataW + hsc_pkg::parity_count(DataW);
  localparam int ResetCycles  = 11;
  localparam int QuietLimit   = 1000;
  localparam int DrainCycles  = 8;
  localparam int RandomPhases = 18;
  localparam int PhaseItems   = 100;

  // One input transaction: a command with both payload words, the unused one carrying noise.
  typedef struct packed {
    hsc_pkg::cmd_e    cmd;
    logic [DataW-1:0] data;
    logic [CodeW-1:0] code;
  } codec_item_t;

  // One result transaction as the block should present it.
  typedef struct packed {
    logic [CodeW-1:0]         code;
    logic [hsc_pkg::SynW-1:0] err_pos;
    logic                     oor;
  } codec_word_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       data_bits_we_i = 1'b0;
  logic [hsc_pkg::CountW-1:0] data_bits_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       cmd_i = 1'b0;
  logic [DataW-1:0]           data_word_i = '0;
  logic [CodeW-1:0]           code_word_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [CodeW-1:0]           code_out_o;
  logic [hsc_pkg::SynW-1:0]   error_position_o;
  logic                       position_out_of_range_o;

  // Items waiting to be driven, and the results predicted for accepted items, oldest first.
  codec_item_t pending_words[$];
  codec_word_t expected_words[$];

  // The testbench's own copy of the data-bit count register; it holds its reset value at first.
  logic [hsc_pkg::CountW-1:0] data_bits_cfg = 6'd4;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;

  hamming_sec_codec #(
    .MAX_DATA_BITS(DataW)
  ) i_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .data_bits_we_i         (data_bits_we_i),
    .data_bits_i            (data_bits_i),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .cmd_i                  (cmd_i),
    .data_word_i            (data_word_i),
    .code_word_i            (code_word_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .code_out_o             (code_out_o),
    .error_position_o       (error_position_o),
    .position_out_of_range_o(position_out_of_range_o)
  );

  always #2 clk_i = ~clk_i;

  // Queue helpers: new entries go to the back.
  function automatic void add_pending(codec_item_t it);
    pending_words = {pending_words, it};
  endfunction

  function automatic void add_expected(codec_word_t res);
    expected_words = {expected_words, res};
  endfunction

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  // The register value in use: zero behaves as one and anything above the widest as the widest.
  function automatic int unsigned effective_m(logic [hsc_pkg::CountW-1:0] cfg);
    int unsigned m;
    m = 32'(cfg);
    if (m < 1) m = 1;
    if (m > DataW) m = DataW;
    return m;
  endfunction

  // Code length: the data bits plus the least parity count r with 2^r >= m + r + 1.
  function automatic int unsigned code_length(int unsigned m);
    int unsigned r;
    r = 1;
    while ((1 << r) < m + r + 1) r++;
    return m + r;
  endfunction

  // XOR of the one-based positions of all set bits within positions 1 to n.
  function automatic logic [hsc_pkg::SynW-1:0] syndrome_of(logic [CodeW-1:0] w,
                                                           int unsigned n);
    logic [hsc_pkg::SynW-1:0] s;
    s = '0;
    for (int unsigned p = 1; p <= n; p++) begin
      if (w[p-1]) s ^= p[hsc_pkg::SynW-1:0];
    end
    return s;
  endfunction

  // Data bits go, lowest first, into the positions that are not powers of two; each parity bit
  // at position 2^i then makes the positions with bit i set XOR to zero.
  function automatic logic [CodeW-1:0] encode_word(logic [DataW-1:0] data, int unsigned m);
    logic [CodeW-1:0]         w;
    logic [hsc_pkg::SynW-1:0] s;
    int unsigned              n;
    int unsigned              j;
    w = '0;
    j = 0;
    n = code_length(m);
    for (int unsigned p = 1; p <= n; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (j < m && data[j]) w[p-1] = 1'b1;
        j++;
      end
    end
    s = syndrome_of(w, n);
    for (int i = 0; i < hsc_pkg::SynW; i++) begin
      if ((1 << i) <= n && s[i]) w[(1 << i) - 1] = 1'b1;
    end
    return w;
  endfunction

  function automatic codec_word_t predict_codec(codec_item_t it,
                                                logic [hsc_pkg::CountW-1:0] cfg);
    codec_word_t      res;
    logic [CodeW-1:0] mask;
    int unsigned      m;
    int unsigned      n;
    m    = effective_m(cfg);
    n    = code_length(m);
    mask = '0;
    for (int unsigned p = 0; p < n; p++) mask[p] = 1'b1;
    res = '0;
    if (it.cmd == hsc_pkg::CMD_ENCODE) begin
      res.code = encode_word(it.data, m);
    end else begin
      // Bits beyond the code length are dropped before the check and never come back.
      res.code    = it.code & mask;
      res.err_pos = syndrome_of(res.code, n);
      if (res.err_pos > n) begin
        res.oor = 1'b1;
      end else if (res.err_pos != 0) begin
        res.code[res.err_pos-1] = ~res.code[res.err_pos-1];
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  function automatic logic [DataW-1:0] rand_data();
    return DataW'({$urandom, $urandom});
  endfunction

  function automatic logic [CodeW-1:0] rand_code();
    return CodeW'({$urandom, $urandom});
  endfunction

  function automatic codec_item_t make_item(hsc_pkg::cmd_e c, logic [DataW-1:0] d,
                                            logic [CodeW-1:0] w);
    codec_item_t it;
    it.cmd  = c;
    it.data = d;
    it.code = w;
    return it;
  endfunction

  // Mostly well-formed traffic: encodes, clean code words (some with junk above the code
  // length), single-bit errors, double-bit errors that may point past the code, and noise.
  function automatic codec_item_t random_item(int unsigned m);
    codec_item_t      it;
    logic [CodeW-1:0] good;
    int unsigned      n;
    int unsigned      a;
    int unsigned      b;
    n    = code_length(m);
    it   = make_item(hsc_pkg::CMD_DECODE, rand_data(), rand_code());
    good = encode_word(rand_data(), m);
    case ($urandom_range(0, 9))
      0, 1, 2: it.cmd = hsc_pkg::CMD_ENCODE;
      3: begin
        for (int unsigned p = 0; p < n; p++) it.code[p] = good[p];
      end
      4: it.code = good;
      5, 6, 7: begin
        it.code = good;
        a = $urandom_range(1, n);
        it.code[a-1] = ~it.code[a-1];
      end
      8: begin
        it.code = good;
        a = $urandom_range(1, n);
        b = $urandom_range(1, n - 1);
        if (b >= a) b++;
        it.code[a-1] = ~it.code[a-1];
        it.code[b-1] = ~it.code[b-1];
      end
      default: ;
    endcase
    return it;
  endfunction

  // Lets everything in flight drain; the register may then be changed safely.
  task automatic wait_idle();
    while (pending_words.size() != 0 || expected_words.size() != 0) @(posedge clk_i);
  endtask

  // Each data-bit count change happens only once the block has nothing in flight.
  task automatic write_data_bits(logic [hsc_pkg::CountW-1:0] value);
    wait_idle();
    @(negedge clk_i);
    data_bits_we_i <= 1'b1;
    data_bits_i    <= value;
    data_bits_cfg  = value;
    @(negedge clk_i);
    data_bits_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------------------
  // Driver: a transaction whose valid is up is held, payload and all, until it is accepted.
  // Otherwise the next pending item is offered, unless the sender chooses to idle this cycle.
  // ---------------------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
      in_valid_i <= 1'b1;
    end else if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      in_valid_i  <= 1'b1;
      cmd_i       <= pending_words[0].cmd;
      data_word_i <= pending_words[0].data;
      code_word_i <= pending_words[0].code;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // The receiver stalls at random, independently of whether a result is on offer.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: predicts on every accepted input transaction, checks every accepted result
  // against the oldest prediction, and watches for the handshakes going quiet.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk_i) begin
    codec_word_t want;
    in_taken  = rst_ni && in_valid_i && !in_stall_o;
    out_taken = rst_ni && out_valid_o && !out_stall_i;
    if (in_taken) begin
      add_expected(predict_codec(
          make_item(hsc_pkg::cmd_e'(cmd_i), data_word_i, code_word_i), data_bits_cfg));
      void'(pending_words.pop_front());
    end
    if (out_taken) begin
      if (expected_words.size() == 0) begin
        $error("result with nothing expected: code_out %h", code_out_o);
        mismatch_count++;
      end else begin
        want = expected_words.pop_front();
        if (code_out_o !== want.code) begin
          $error("code_out: expected %h, actual %h", want.code, code_out_o);
          mismatch_count++;
        end
        if (error_position_o !== want.err_pos) begin
          $error("error_position: expected %0d, actual %0d", want.err_pos, error_position_o);
          mismatch_count++;
        end
        if (position_out_of_range_o !== want.oor) begin
          $error("position_out_of_range: expected %b, actual %b", want.oor,
                 position_out_of_range_o);
          mismatch_count++;
        end
      end
    end
    if (rst_ni) begin
      if (in_taken || out_taken) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("hamming_sec_codec_tb: done, errors");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sequence: reset, a directed part over a few data-bit counts, then random phases that step
  // through many counts (the extremes and the out-of-range register values among them) while
  // the idling pattern moves from a slow receiver to a slow sender and finally to full rate.
  // ---------------------------------------------------------------------------------------
  initial begin
    logic [CodeW-1:0]           w;
    logic [hsc_pkg::CountW-1:0] setting;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 34;
    recv_idle_pct = 49;

    // The reset count of four gives a full seven-bit code, so no syndrome can point past it.
    add_pending(make_item(hsc_pkg::CMD_ENCODE, '0, rand_code()));
    add_pending(make_item(hsc_pkg::CMD_ENCODE, '1, '0));
    add_pending(make_item(hsc_pkg::CMD_DECODE, '0, '0));
    add_pending(make_item(hsc_pkg::CMD_DECODE, rand_data(), '1));
    w = encode_word(57'hB, 4);
    w[2] = ~w[2];
    add_pending(make_item(hsc_pkg::CMD_DECODE, '1, w));
    // Only the topmost bit set: it lies beyond the code and must be ignored.
    add_pending(make_item(hsc_pkg::CMD_DECODE, '0, {1'b1, {(CodeW - 1){1'b0}}}));

    // The largest register value stands for the widest code of 63 positions.
    write_data_bits(6'd63);
    add_pending(make_item(hsc_pkg::CMD_ENCODE, '1, rand_code()));
    add_pending(make_item(hsc_pkg::CMD_ENCODE, {1'b1, {(DataW - 1){1'b0}}}, '1));
    w = encode_word(rand_data(), DataW);
    w[CodeW-1] = ~w[CodeW-1];
    add_pending(make_item(hsc_pkg::CMD_DECODE, '0, w));
    add_pending(make_item(hsc_pkg::CMD_DECODE, '0, '1));
    add_pending(make_item(hsc_pkg::CMD_DECODE, '1, 63'h1));

    // Zero behaves as a single data bit with a three-position code.
    write_data_bits(6'd0);
    add_pending(make_item(hsc_pkg::CMD_ENCODE, 57'h1, '0));
    add_pending(make_item(hsc_pkg::CMD_DECODE, '0, 63'h7));
    add_pending(make_item(hsc_pkg::CMD_DECODE, '0, 63'h1));
    add_pending(make_item(hsc_pkg::CMD_DECODE, '0, '1));

    // Five data bits give a nine-position code whose syndromes reach fifteen: positions
    // seven and eight together, or six and nine, point past the code and are only flagged.
    write_data_bits(6'd5);
    add_pending(make_item(hsc_pkg::CMD_DECODE, '0, 63'h0C0));
    add_pending(make_item(hsc_pkg::CMD_DECODE, '0, 63'h100));
    add_pending(make_item(hsc_pkg::CMD_DECODE, '0, 63'h120));
    add_pending(make_item(hsc_pkg::CMD_ENCODE, '1, '0));

    for (int k = 0; k < RandomPhases; k++) begin
      case (k)
        0:       setting = 6'd1;
        1:       setting = 6'd57;
        2:       setting = 6'd5;
        3:       setting = 6'd0;
        4:       setting = 6'd63;
        5:       setting = 6'd11;
        6:       setting = 6'd26;
        7:       setting = 6'd58;
        8:       setting = 6'd2;
        9:       setting = 6'd4;
        10:      setting = 6'd3;
        11:      setting = 6'd12;
        12:      setting = 6'd57;
        13:      setting = 6'd1;
        14:      setting = 6'd5;
        default: setting = hsc_pkg::CountW'($urandom_range(0, 63));
      endcase
      write_data_bits(setting);
      if (k < 6) begin
        send_idle_pct = 34;
        recv_idle_pct = 49;
      end else if (k < 12) begin
        send_idle_pct = 49;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int i = 0; i < PhaseItems; i++) begin
        add_pending(random_item(effective_m(data_bits_cfg)));
      end
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("hamming_sec_codec_tb: done, clean");
    end else begin
      $display("hamming_sec_codec_tb: done, errors");
    end
    $finish;
  end

endmodule

### files.f
hdl/hsc_pkg.sv
hdl/hsc_syndrome.sv
hdl/hsc_core.sv
hdl/hamming_sec_codec.sv
tb/hamming_sec_codec_tb.sv
